[design/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the matrix-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int NLANE = 4;   // w, x, y, z
  localparam int OW    = 16;  // width of every matrix entry and result field
  localparam int QW    = 17;  // quotient bits kept before saturation

  localparam logic [QW-1:0] QPOS_MAX = QW'(32767);
  localparam logic [QW-1:0] QNEG_MAX = QW'(32768);

  typedef logic signed [OW-1:0] elem_t;

  // sideband that travels with each item down the pipe
  typedef struct packed {
    logic [NLANE-1:0] neg;
    logic             deg;
  } side_t;

  // axis codes for the largest diagonal entry
  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

endpackage

[design/rmq_if.sv]
// ----------------------------------------------------------------------------
// rmq channel interfaces
// Valid/ready channels for matrix items in and quaternion items out.
// ----------------------------------------------------------------------------
interface rmq_in_if;
  import rmq_pkg::*;
  logic  valid;
  logic  ready;
  elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic  valid;
  logic  ready;
  elem_t qw, qx, qy, qz;
  logic  degenerate;

  modport source (output valid, qw, qx, qy, qz, degenerate, input ready);
  modport sink   (input valid, qw, qx, qy, qz, degenerate, output ready);
endinterface

[design/rmq_divider.sv]
// ----------------------------------------------------------------------------
// rmq_divider
// Four-lane restoring divider, one quotient bit per stage, with rounding
// offset and overflow detection folded into the first stage.
// ----------------------------------------------------------------------------
module rmq_divider
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter int MW        = 17,
  parameter int RTW       = 19
) (
  input  logic             clk,
  input  logic [QW:0]      ld,
  input  logic [MW-1:0]    mag_i [NLANE],
  input  logic [RTW-1:0]   n_i,
  output logic [QW-1:0]    q_o   [NLANE],
  output logic             ovf_o [NLANE]
);

  localparam int NW = MW + FRAC_BITS + 1;
  localparam int EW = NW + RTW + QW;

  logic [RTW-1:0] n_r   [QW+1];
  logic [RTW-1:0] rem_r [QW+1][NLANE];
  logic [QW-1:0]  qr_r  [QW+1][NLANE];
  logic           ovf_r [QW+1][NLANE];

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    logic [NW-1:0] num;
    logic          ovf_nxt;
    assign num     = (NW'(mag_i[l]) << FRAC_BITS) + NW'(n_i >> 1);
    assign ovf_nxt = EW'(num) >= (EW'(n_i) << QW);

    always_ff @(posedge clk) begin
      if (ld[0]) begin
        rem_r[0][l] <= RTW'(num >> QW);
        qr_r[0][l]  <= num[QW-1:0];
        ovf_r[0][l] <= ovf_nxt;
      end
    end

    for (genvar d = 1; d <= QW; d++) begin : g_step
      logic [RTW:0]   rt;
      logic           ge;
      logic [RTW:0]   rd;
      assign rt = {rem_r[d-1][l], qr_r[d-1][l][QW-1]};
      assign ge = rt >= {1'b0, n_r[d-1]};
      assign rd = ge ? (rt - {1'b0, n_r[d-1]}) : rt;

      always_ff @(posedge clk) begin
        if (ld[d]) begin
          rem_r[d][l] <= rd[RTW-1:0];
          qr_r[d][l]  <= {qr_r[d-1][l][QW-2:0], ge};
          ovf_r[d][l] <= ovf_r[d-1][l];
        end
      end
    end

    assign q_o[l]   = qr_r[QW][l];
    assign ovf_o[l] = ovf_r[QW][l];
  end

  always_ff @(posedge clk) begin
    if (ld[0]) n_r[0] <= n_i;
    for (int d = 1; d <= QW; d++) begin
      if (ld[d]) n_r[d] <= n_r[d-1];
    end
  end

endmodule

[design/rotation_matrix_to_quaternion.sv]
// Depth: 3 + ST + QW + 2 register stages, 40 at FRAC_BITS = 14 (ST = 18 root bits, QW = 17).
// Throughput: one item per cycle unless out_ch.ready is low and back-pressure
// reaches the input; every stage holds one item and bubbles close up.
// The depth is set by the bit-serial root (one result bit a stage) and the
// restoring dividers (one quotient bit a stage).
// Reset clears the valid bits only; data registers keep whatever they held.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Pipelined conversion of a 3x3 fixed-point rotation matrix to a unit
// quaternion, normalised by an integer square root and four dividers.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);

  // component width: enough for t = diag terms + 1.0 at any fraction width
  localparam int CW     = (FRAC_BITS >= 16) ? FRAC_BITS + 3 : 18;
  localparam int MW     = CW - 1;            // magnitude
  localparam int SQW    = 2 * MW;            // one square
  localparam int SUMW   = SQW + 2;           // sum of four squares
  localparam int ST     = (SUMW + 1) / 2;    // root bits, one per stage
  localparam int SPW    = 2 * ST;
  localparam int RTW    = ST;
  localparam int RMW    = RTW + 3;

  // stage map
  localparam int S_C    = 0;                 // components
  localparam int S_SQ   = 1;                 // squares
  localparam int S_SUM  = 2;                 // sum of squares
  localparam int S_RT0  = 3;                 // first root stage
  localparam int S_DIV0 = S_RT0 + ST;        // divider set-up
  localparam int S_OUT  = S_DIV0 + QW + 1;   // saturation and output register
  localparam int NST    = S_OUT + 1;

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its successor loads.
  // --------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic [NST:0]   load;

  assign load[NST] = out_ch.ready;
  for (genvar k = 0; k < NST; k++) begin : g_load
    assign load[k] = ~v_r[k] | load[k+1];
  end
  assign in_ch.ready  = load[0];
  assign out_ch.valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (load[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < NST; k++) begin
        if (load[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // sidebands and magnitudes carried alongside the data
  side_t         sb_r  [NST];
  logic [MW-1:0] mag_r [S_DIV0][NLANE];

  // --------------------------------------------------------------------------
  // Stage 0: pick the branch and form the four components.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [CW-1:0] one, trace, t;
  logic signed [CW-1:0] c [NLANE];
  axis_t                ax;

  assign e00 = CW'(in_ch.r00);
  assign e01 = CW'(in_ch.r01);
  assign e02 = CW'(in_ch.r02);
  assign e10 = CW'(in_ch.r10);
  assign e11 = CW'(in_ch.r11);
  assign e12 = CW'(in_ch.r12);
  assign e20 = CW'(in_ch.r20);
  assign e21 = CW'(in_ch.r21);
  assign e22 = CW'(in_ch.r22);
  assign one   = CW'(1) <<< FRAC_BITS;
  assign trace = e00 + e11 + e22;

  always_comb begin
    // largest diagonal entry, ties keep the lower axis
    if (e22 > ((e11 > e00) ? e11 : e00)) ax = AX_Z;
    else if (e11 > e00)                  ax = AX_Y;
    else                                 ax = AX_X;

    if (trace > 0) begin
      t    = trace + one;
      c[0] = t;
      c[1] = e21 - e12;
      c[2] = e02 - e20;
      c[3] = e10 - e01;
    end else begin
      unique case (ax)
        AX_X: begin
          t    = e00 - e11 - e22 + one;
          c[1] = t;
          c[0] = e21 - e12;
          c[2] = e10 + e01;
          c[3] = e20 + e02;
        end
        AX_Y: begin
          t    = e11 - e22 - e00 + one;
          c[2] = t;
          c[0] = e02 - e20;
          c[3] = e21 + e12;
          c[1] = e01 + e10;
        end
        default: begin
          t    = e22 - e00 - e11 + one;
          c[3] = t;
          c[0] = e10 - e01;
          c[1] = e02 + e20;
          c[2] = e12 + e21;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load[S_C]) begin
      sb_r[S_C].deg <= (t <= 0);
      for (int l = 0; l < NLANE; l++) begin
        sb_r[S_C].neg[l] <= c[l][CW-1];
        mag_r[S_C][l]    <= c[l][CW-1] ? MW'(-c[l]) : MW'(c[l]);
      end
    end
  end

  // carry sideband and magnitudes through the stages that do not change them
  for (genvar k = 1; k < NST; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (load[k]) sb_r[k] <= sb_r[k-1];
    end
  end
  for (genvar k = 1; k < S_DIV0; k++) begin : g_mag
    always_ff @(posedge clk) begin
      if (load[k]) mag_r[k] <= mag_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1 and 2: squares, then their sum.
  // --------------------------------------------------------------------------
  logic [SQW-1:0]  sq_r [NLANE];
  logic [SUMW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (load[S_SQ]) begin
      for (int l = 0; l < NLANE; l++) sq_r[l] <= mag_r[S_C][l] * mag_r[S_C][l];
    end
    if (load[S_SUM]) begin
      sum_r <= (SUMW'(sq_r[0]) + SUMW'(sq_r[1])) + (SUMW'(sq_r[2]) + SUMW'(sq_r[3]));
    end
  end

  // --------------------------------------------------------------------------
  // Root stages: digit-by-digit integer square root, one bit a stage.
  // --------------------------------------------------------------------------
  logic [RMW-1:0] rem_r  [ST];
  logic [RTW-1:0] root_r [ST];
  logic [SPW-1:0] sp_r   [ST];

  for (genvar s = 0; s < ST; s++) begin : g_root
    logic [RMW-1:0] rem_p, rem_t, trial, rem_n;
    logic [RTW-1:0] root_p;
    logic [SPW-1:0] sp_p;
    logic           ge;

    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign sp_p   = SPW'(sum_r);
    end else begin : g_next
      assign rem_p  = rem_r[s-1];
      assign root_p = root_r[s-1];
      assign sp_p   = sp_r[s-1];
    end

    assign rem_t = {rem_p[RMW-3:0], sp_p[SPW-1 -: 2]};
    assign trial = RMW'({root_p, 2'b01});
    assign ge    = rem_t >= trial;
    assign rem_n = ge ? (rem_t - trial) : rem_t;

    always_ff @(posedge clk) begin
      if (load[S_RT0+s]) begin
        rem_r[s]  <= rem_n;
        root_r[s] <= {root_p[RTW-2:0], ge};
        sp_r[s]   <= sp_p << 2;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: each component times 2^FRAC_BITS over the norm, rounded.
  // --------------------------------------------------------------------------
  logic [QW-1:0] q   [NLANE];
  logic          ovf [NLANE];

  rmq_divider #(
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW),
    .RTW       (RTW)
  ) u_div (
    .clk   (clk),
    .ld    (load[S_DIV0 +: QW+1]),
    .mag_i (mag_r[S_DIV0-1]),
    .n_i   (root_r[ST-1]),
    .q_o   (q),
    .ovf_o (ovf)
  );

  // --------------------------------------------------------------------------
  // Output stage: apply sign, saturate, zero a degenerate item.
  // --------------------------------------------------------------------------
  elem_t res [NLANE];
  elem_t qo_r [NLANE];
  logic  deg_r;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (sb_r[S_OUT-1].deg) begin
        res[l] = '0;
      end else if (sb_r[S_OUT-1].neg[l]) begin
        res[l] = (ovf[l] || q[l] > QNEG_MAX) ? elem_t'(-32768) : OW'(-q[l]);
      end else begin
        res[l] = (ovf[l] || q[l] > QPOS_MAX) ? elem_t'(32767) : OW'(q[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[S_OUT]) begin
      qo_r  <= res;
      deg_r <= sb_r[S_OUT-1].deg;
    end
  end

  assign out_ch.qw         = qo_r[0];
  assign out_ch.qx         = qo_r[1];
  assign out_ch.qy         = qo_r[2];
  assign out_ch.qz         = qo_r[3];
  assign out_ch.degenerate = deg_r;

endmodule

[tb/rmq_test_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq test channel interfaces
// Not needed: the block's own interfaces in design/rmq_if.sv are used as is.
// This file holds the item record shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package rmq_test_pkg;
  import rmq_pkg::*;

  typedef struct {
    elem_t m [3][3];
  } matrix_t;

  typedef struct {
    elem_t qw, qx, qy, qz;
    logic  deg;
  } quat_t;
endpackage

[tb/rmq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_checker
// Watches both channels, predicts each quaternion from the accepted matrix
// and compares it with the oldest pending prediction.
// ----------------------------------------------------------------------------
module rmq_checker
  import rmq_pkg::*;
  import rmq_test_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic    clk,
  input  logic    rst_n,
  rmq_in_if.sink  in_mon,
  rmq_out_if.sink out_mon,
  output int      fail_count,
  output int      pending
);

  quat_t quat_queue[$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic elem_t scale_lane(longint c, longint unsigned n);
    longint unsigned mag, q;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    q = ((mag << FRAC_BITS) + (n >> 1)) / n;
    if (c < 0) return (q > 32768) ? elem_t'(-32768) : elem_t'(-longint'(q));
    return (q > 32767) ? elem_t'(32767) : elem_t'(q);
  endfunction

  function automatic quat_t predict_quat(matrix_t mx);
    longint m [3][3];
    longint c [4];
    longint tr, t;
    longint unsigned s, n;
    int a, i, j, k;
    quat_t q;
    for (int r = 0; r < 3; r++)
      for (int cl = 0; cl < 3; cl++) m[r][cl] = mx.m[r][cl];
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      t = tr + (64'sd1 << FRAC_BITS);
      c[0] = t;
      c[1] = m[2][1] - m[1][2];
      c[2] = m[0][2] - m[2][0];
      c[3] = m[1][0] - m[0][1];
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      t = m[i][i] - m[j][j] - m[k][k] + (64'sd1 << FRAC_BITS);
      c[1 + i] = t;
      c[0] = m[k][j] - m[j][k];
      c[1 + j] = m[j][i] + m[i][j];
      c[1 + k] = m[k][i] + m[i][k];
    end
    s = 0;
    for (a = 0; a < 4; a++) s += longint'(c[a] * c[a]);
    n = root_floor(s);
    if (t <= 0 || n == 0) begin
      q.qw = '0; q.qx = '0; q.qy = '0; q.qz = '0; q.deg = 1'b1;
    end else begin
      q.qw = scale_lane(c[0], n);
      q.qx = scale_lane(c[1], n);
      q.qy = scale_lane(c[2], n);
      q.qz = scale_lane(c[3], n);
      q.deg = 1'b0;
    end
    return q;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  assign pending = quat_queue.size();

  always @(posedge clk) begin
    matrix_t mx;
    quat_t   want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        mx.m[0][0] = in_mon.r00; mx.m[0][1] = in_mon.r01; mx.m[0][2] = in_mon.r02;
        mx.m[1][0] = in_mon.r10; mx.m[1][1] = in_mon.r11; mx.m[1][2] = in_mon.r12;
        mx.m[2][0] = in_mon.r20; mx.m[2][1] = in_mon.r21; mx.m[2][2] = in_mon.r22;
        quat_queue.push_back(predict_quat(mx));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (quat_queue.size() == 0) begin
          $error("quaternion item with no matrix pending");
          fail_count++;
        end else begin
          want = quat_queue.pop_front();
          compare_field("qw", want.qw, out_mon.qw);
          compare_field("qx", want.qx, out_mon.qx);
          compare_field("qy", want.qy, out_mon.qy);
          compare_field("qz", want.qz, out_mon.qz);
          compare_field("degenerate", want.deg, out_mon.degenerate);
        end
      end
    end
  end

endmodule

[tb/rotation_matrix_to_quaternion_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Drives matrices into the pipeline: directed corner cases first, then random
// rotations, perturbed rotations and raw noise, under three idling regimes.
// The checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;
  import rmq_test_pkg::*;

  localparam int FRAC_BITS  = 14;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int LATENCY    = 40;
  localparam int DRAIN_WAIT = 4 * LATENCY;
  localparam int STALL_MAX  = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   quiet_cycles = 0;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  rmq_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch.sink),
    .out_mon    (out_ch.sink),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Receiver: stall at the configured rate, one decision per edge.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("rotation_matrix_to_quaternion test failed");
      $finish;
    end
  end

  // Present one matrix and hold it until accepted; idle gaps come before it.
  task automatic send_matrix(matrix_t mx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.r00 <= mx.m[0][0]; in_ch.r01 <= mx.m[0][1]; in_ch.r02 <= mx.m[0][2];
    in_ch.r10 <= mx.m[1][0]; in_ch.r11 <= mx.m[1][1]; in_ch.r12 <= mx.m[1][2];
    in_ch.r20 <= mx.m[2][0]; in_ch.r21 <= mx.m[2][1]; in_ch.r22 <= mx.m[2][2];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic matrix_t fill_matrix(int v);
    matrix_t mx;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) mx.m[r][c] = elem_t'(v);
    return mx;
  endfunction

  // Build a rotation from a random near-unit quaternion (floating point),
  // then jitter a few LSBs so that rounding and branch edges get exercised.
  function automatic matrix_t random_rotation(int jitter);
    real w, x, y, z, nrm, e [3][3];
    matrix_t mx;
    w = $urandom_range(2000) - 1000.0;
    x = $urandom_range(2000) - 1000.0;
    y = $urandom_range(2000) - 1000.0;
    z = $urandom_range(2000) - 1000.0;
    // Push some items towards one dominant axis to hit each branch.
    case ($urandom_range(4))
      0: w = w * 8.0;
      1: x = x * 8.0;
      2: y = y * 8.0;
      3: z = z * 8.0;
      default: ;
    endcase
    nrm = $sqrt(w * w + x * x + y * y + z * z);
    if (nrm == 0.0) begin
      w = 1.0; nrm = 1.0;
    end
    w /= nrm; x /= nrm; y /= nrm; z /= nrm;
    e[0][0] = 1 - 2 * (y * y + z * z); e[0][1] = 2 * (x * y - z * w);
    e[0][2] = 2 * (x * z + y * w);     e[1][0] = 2 * (x * y + z * w);
    e[1][1] = 1 - 2 * (x * x + z * z); e[1][2] = 2 * (y * z - x * w);
    e[2][0] = 2 * (x * z - y * w);     e[2][1] = 2 * (y * z + x * w);
    e[2][2] = 1 - 2 * (x * x + y * y);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        mx.m[r][c] = elem_t'($rtoi(e[r][c] * ONE) +
                             $signed($urandom_range(2 * jitter)) - jitter);
    return mx;
  endfunction

  function automatic matrix_t random_noise();
    matrix_t mx;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) mx.m[r][c] = elem_t'($urandom);
    return mx;
  endfunction

  // Directed corners: identity, half turns about each axis, all-extreme
  // entries, ties on the diagonal, large off-diagonal entries.
  task automatic run_directed();
    matrix_t mx;
    mx = fill_matrix(0);
    send_matrix(mx);                                 // zero trace, t = 1.0
    mx.m[0][0] = ONE; mx.m[1][1] = ONE; mx.m[2][2] = ONE;
    send_matrix(mx);                                 // identity
    mx = fill_matrix(0);
    mx.m[0][0] = ONE; mx.m[1][1] = -ONE; mx.m[2][2] = -ONE;
    send_matrix(mx);                                 // half turn about x
    mx.m[0][0] = -ONE; mx.m[1][1] = ONE;
    send_matrix(mx);                                 // half turn about y
    mx.m[1][1] = -ONE; mx.m[2][2] = ONE;
    send_matrix(mx);                                 // half turn about z
    send_matrix(fill_matrix(32767));
    send_matrix(fill_matrix(-32768));
    send_matrix(fill_matrix(-1));
    send_matrix(fill_matrix(-ONE));                  // ties, t = 2.0
    mx = fill_matrix(0);
    mx.m[0][0] = -ONE; mx.m[1][1] = -ONE; mx.m[2][2] = -ONE;
    mx.m[0][0] = 0; mx.m[1][1] = ONE / 2; mx.m[2][2] = -ONE / 2 - ONE;
    send_matrix(mx);                                 // non-trace, y leads
    mx = fill_matrix(0);
    mx.m[0][0] = -ONE; mx.m[1][1] = 0; mx.m[2][2] = ONE;
    send_matrix(mx);                                 // zero trace, z leads
    mx = fill_matrix(0);
    mx.m[0][0] = -32768; mx.m[1][1] = 32767; mx.m[2][2] = 32767;
    send_matrix(mx);                                 // extreme diagonal, positive trace
    mx = fill_matrix(0);
    mx.m[0][0] = -32768; mx.m[1][1] = -32768; mx.m[2][2] = -32768;
    mx.m[0][1] = 32767; mx.m[1][0] = 32767;
    send_matrix(mx);
    mx = fill_matrix(0);
    mx.m[2][1] = 32767; mx.m[1][2] = -32768; mx.m[0][0] = 1;
    send_matrix(mx);                                 // large off-diagonal entries
    mx = fill_matrix(0);
    mx.m[0][1] = 32767; mx.m[1][0] = -32768; mx.m[0][2] = -32768;
    mx.m[2][0] = 32767; mx.m[2][2] = 1;
    send_matrix(mx);
    mx = fill_matrix(0);
    mx.m[0][0] = 32767; mx.m[1][1] = -32768; mx.m[2][2] = 0;
    send_matrix(mx);
    mx = fill_matrix(21845);                          // alternating bit patterns
    send_matrix(mx);
    send_matrix(fill_matrix(-21846));
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1:    send_matrix(random_noise());
        2:       send_matrix(random_rotation(64));
        default: send_matrix(random_rotation(2));
      endcase
    end
  endtask

  // Drop valid after the last item, then wait for every result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    // Start every input at a known value.
    in_ch.valid <= 1'b0;
    {in_ch.r00, in_ch.r01, in_ch.r02, in_ch.r10, in_ch.r11, in_ch.r12,
     in_ch.r20, in_ch.r21, in_ch.r22} <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15; recv_idle_pct = 66;
    run_directed();
    run_random(600);
    // Hold the sender until the pipe has emptied completely.
    drain();
    send_idle_pct = 66; recv_idle_pct = 15;
    run_random(650);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_random(650);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("rotation_matrix_to_quaternion test passed");
    else
      $display("rotation_matrix_to_quaternion test failed");
    $finish;
  end

endmodule
